FILE: rtl/lsqr_pkg.sv
// load/store queue ring: shared field widths, operation codes and beat types
// depends on nothing; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package lsqr_pkg;

  localparam int FUNC_W = 3;
  localparam int WORD_W = 32;
  localparam int SLOT_W = 5;
  localparam int TAG_W  = 4;

  // operation codes carried in func
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RETIRE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FLUSH  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] instr_pc;
    logic              is_store;
    logic [TAG_W-1:0]  branch_tag;
    logic [SLOT_W-1:0] slot_in;
    logic              addr_ok_in;
    logic [WORD_W-1:0] mem_addr_in;
  } in_beat_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [WORD_W-1:0] pc_out;
    logic              store_out;
    logic [TAG_W-1:0]  tag_out;
    logic [WORD_W-1:0] addr_out;
    logic              addr_ok_out;
    logic              live_out;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;    // clear one live bit of the reset sweep
    logic take;        // latch the input beat and read the entry
    logic commit;      // perform the latched operation, load the result
    logic flush_start; // rewind the sweep counter for a flush
    logic sweep_step;  // one step of the flush sweep
    logic flush_post;  // load the flush result
  } lsqr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sweep_done;
    logic out_free;
    logic is_flush;
  } lsqr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lsqr_if.sv
// load/store queue ring: input and result channel interfaces (valid/ready)
// depends on lsqr_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lsqr_in_if import lsqr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] instr_pc;
  logic              is_store;
  logic [TAG_W-1:0]  branch_tag;
  logic [SLOT_W-1:0] slot_in;
  logic              addr_ok_in;
  logic [WORD_W-1:0] mem_addr_in;

  modport source (output valid, func, instr_pc, is_store, branch_tag, slot_in,
                  addr_ok_in, mem_addr_in, input ready);
  modport sink   (input valid, func, instr_pc, is_store, branch_tag, slot_in,
                  addr_ok_in, mem_addr_in, output ready);
endinterface

interface lsqr_out_if import lsqr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot_out;
  logic [WORD_W-1:0] pc_out;
  logic              store_out;
  logic [TAG_W-1:0]  tag_out;
  logic [WORD_W-1:0] addr_out;
  logic              addr_ok_out;
  logic              live_out;

  modport source (output valid, ok, slot_out, pc_out, store_out, tag_out,
                  addr_out, addr_ok_out, live_out, input ready);
  modport sink   (input valid, ok, slot_out, pc_out, store_out, tag_out,
                  addr_out, addr_ok_out, live_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/load_store_queue_ring_top.sv
// Circular load/store queue with allocate, retire, address update, flush by
// tag and peek. Every operation but flush first latches the beat and reads the
// entry memories, then, once the result register is free, updates pointers
// and loads the result register; a new beat is taken while the previous
// result still waits on the output side. A flush walks the tag memory one
// slot per cycle. After reset the live bits are cleared by a pass over every
// slot, during which no beat is accepted.
// depends on lsqr_pkg, lsqr_if, lsqr_ctrl and lsqr_dpath
`timescale 1ns / 1ps
`default_nettype none

module load_store_queue_ring_top import lsqr_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 4
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lsqr_in_if.sink    in_bus,
  lsqr_out_if.source out_bus
);

  lsqr_cmd_t  cmd;
  lsqr_stat_t stat;
  in_beat_t   in_beat;
  out_beat_t  out_beat;
  logic       out_valid;
  logic       in_ready;

  // input beat packing
  assign in_beat.func        = in_bus.func;
  assign in_beat.instr_pc    = in_bus.instr_pc;
  assign in_beat.is_store    = in_bus.is_store;
  assign in_beat.branch_tag  = in_bus.branch_tag;
  assign in_beat.slot_in     = in_bus.slot_in;
  assign in_beat.addr_ok_in  = in_bus.addr_ok_in;
  assign in_beat.mem_addr_in = in_bus.mem_addr_in;
  assign in_bus.ready        = in_ready;

  lsqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsqr_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_beat   (in_beat),
    .out_beat  (out_beat),
    .out_valid (out_valid),
    .out_ready (out_bus.ready)
  );

  // result beat unpacking
  assign out_bus.valid       = out_valid;
  assign out_bus.ok          = out_beat.ok;
  assign out_bus.slot_out    = out_beat.slot_out;
  assign out_bus.pc_out      = out_beat.pc_out;
  assign out_bus.store_out   = out_beat.store_out;
  assign out_bus.tag_out     = out_beat.tag_out;
  assign out_bus.addr_out    = out_beat.addr_out;
  assign out_bus.addr_ok_out = out_beat.addr_ok_out;
  assign out_bus.live_out    = out_beat.live_out;

endmodule

`default_nettype wire

FILE: rtl/lsqr_ctrl.sv
// load/store queue ring: controller state machine
// depends on lsqr_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lsqr_ctrl import lsqr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lsqr_stat_t stat,
  output lsqr_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FDONE = 5'b10000
  } lsqr_state_t;

  lsqr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_flush) begin
          cmd.flush_start = 1'b1;
          state_nxt       = ST_FLUSH;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.sweep_done) begin
          state_nxt = ST_FDONE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_FDONE: begin
        if (stat.out_free) begin
          cmd.flush_post = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lsqr_dpath.sv
// load/store queue ring: entry memories, head/tail pointers, sweep counter
// and the result register; depends on lsqr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsqr_dpath import lsqr_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lsqr_cmd_t cmd,
  output lsqr_stat_t     stat,
  input  wire in_beat_t  in_beat,
  output out_beat_t      out_beat,
  output logic           out_valid,
  input  wire logic      out_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // entry memories
  logic [WORD_W-1:0]   pc_mem   [QUEUE_DEPTH];
  logic [WORD_W-1:0]   addr_mem [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_mem  [QUEUE_DEPTH];
  logic                kind_mem [QUEUE_DEPTH];
  logic                aok_mem  [QUEUE_DEPTH];
  logic                live_mem [QUEUE_DEPTH];

  logic [WORD_W-1:0]   pc_q, addr_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                kind_q, aok_q, live_q;

  in_beat_t            op_r;
  logic [PTR_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic                empty_r, empty_nxt;
  logic [CNT_W-1:0]    idx_r;
  logic                fwr_vld_r;
  logic [PTR_W-1:0]    fwr_idx_r;
  out_beat_t           out_r, out_nxt;
  logic                out_valid_r;

  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic                sweep_rd;
  logic                alloc_we, upd_we;
  logic [PTR_W-1:0]    ent_wa;
  logic [WORD_W-1:0]   addr_wd;
  logic                aok_wd;
  logic                live_we, live_wd;
  logic [PTR_W-1:0]    live_wa;
  logic                full, slot_in_range;
  logic [PTR_W-1:0]    alloc_slot;
  logic [TAG_BITS-1:0] op_tag;

  assign op_tag        = TAG_BITS'(op_r.branch_tag);
  assign full          = !empty_r && (next_slot(tail_r) == head_r);
  assign alloc_slot    = empty_r ? '0 : next_slot(tail_r);
  assign slot_in_range = (32'(op_r.slot_in) < 32'(QUEUE_DEPTH));
  assign sweep_rd      = cmd.sweep_step && (idx_r != DEPTH_CNT);

  // read address: sweep index, update slot or head
  always_comb begin
    rd_en = cmd.take || sweep_rd;
    if (sweep_rd) begin
      rd_addr = idx_r[PTR_W-1:0];
    end else if (in_beat.func == FN_UPDATE) begin
      rd_addr = PTR_W'(in_beat.slot_in);
    end else begin
      rd_addr = head_r;
    end
  end

  // operation, pointer update and result
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    alloc_we  = 1'b0;
    upd_we    = 1'b0;
    live_we   = 1'b0;
    live_wd   = 1'b0;
    live_wa   = head_r;
    out_nxt   = '0;
    if (cmd.commit) begin
      unique case (op_r.func)
        FN_ALLOC: begin
          if (!full) begin
            alloc_we         = 1'b1;
            live_we          = 1'b1;
            live_wd          = 1'b1;
            live_wa          = alloc_slot;
            head_nxt         = empty_r ? '0 : head_r;
            tail_nxt         = alloc_slot;
            empty_nxt        = 1'b0;
            out_nxt.ok       = 1'b1;
            out_nxt.slot_out = SLOT_W'(alloc_slot);
          end
        end
        FN_RETIRE, FN_PEEK: begin
          if (!empty_r) begin
            out_nxt.ok          = 1'b1;
            out_nxt.slot_out    = SLOT_W'(head_r);
            out_nxt.pc_out      = pc_q;
            out_nxt.store_out   = kind_q;
            out_nxt.tag_out     = TAG_W'(tag_q);
            out_nxt.addr_out    = addr_q;
            out_nxt.addr_ok_out = aok_q;
            out_nxt.live_out    = live_q;
            if (op_r.func == FN_RETIRE) begin
              live_we = 1'b1;
              live_wa = head_r;
              if (head_r == tail_r) begin
                empty_nxt = 1'b1;
              end else begin
                head_nxt = next_slot(head_r);
              end
            end
          end
        end
        FN_UPDATE: begin
          if (slot_in_range && live_q) begin
            upd_we     = 1'b1;
            out_nxt.ok = 1'b1;
          end
        end
        default: begin
          out_nxt = '0;
        end
      endcase
    end else if (cmd.flush_post) begin
      out_nxt.ok = 1'b1;
    end
    // sweeps own the live port outside of commit
    if (cmd.clr_step) begin
      live_we = 1'b1;
      live_wd = 1'b0;
      live_wa = idx_r[PTR_W-1:0];
    end else if (fwr_vld_r && (tag_q == op_tag)) begin
      live_we = 1'b1;
      live_wd = 1'b0;
      live_wa = fwr_idx_r;
    end
  end

  // entry write port: allocate or address update
  always_comb begin
    ent_wa  = alloc_we ? alloc_slot : PTR_W'(op_r.slot_in);
    addr_wd = alloc_we ? '0 : op_r.mem_addr_in;
    aok_wd  = alloc_we ? 1'b0 : op_r.addr_ok_in;
  end

  // memories, written at the entry and live addresses and read registered
  always_ff @(posedge clk) begin
    if (alloc_we) begin
      pc_mem[ent_wa]   <= op_r.instr_pc;
      tag_mem[ent_wa]  <= op_tag;
      kind_mem[ent_wa] <= op_r.is_store;
    end
    if (alloc_we || upd_we) begin
      addr_mem[ent_wa] <= addr_wd;
      aok_mem[ent_wa]  <= aok_wd;
    end
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (rd_en) begin
      pc_q   <= pc_mem[rd_addr];
      addr_q <= addr_mem[rd_addr];
      tag_q  <= tag_mem[rd_addr];
      kind_q <= kind_mem[rd_addr];
      aok_q  <= aok_mem[rd_addr];
      live_q <= live_mem[rd_addr];
    end
  end

  // latched operation
  always_ff @(posedge clk) begin
    if (cmd.take) op_r <= in_beat;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // sweep counter shared by the reset clear and the flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      fwr_vld_r <= 1'b0;
    end else if (cmd.clr_step || cmd.flush_start) begin
      idx_r     <= (cmd.clr_step && idx_r[PTR_W-1:0] != LAST_SLOT) ? idx_r + 1'b1 : '0;
      fwr_vld_r <= 1'b0;
    end else if (cmd.sweep_step) begin
      fwr_vld_r <= sweep_rd;
      if (sweep_rd) idx_r <= idx_r + 1'b1;
    end else begin
      fwr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_rd) fwr_idx_r <= idx_r[PTR_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.flush_post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.flush_post) out_r <= out_nxt;
  end

  assign out_beat   = out_r;
  assign out_valid  = out_valid_r;

  assign stat.clr_last   = (idx_r[PTR_W-1:0] == LAST_SLOT);
  assign stat.sweep_done = (idx_r == DEPTH_CNT) && !fwr_vld_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.is_flush   = (op_r.func == FN_FLUSH);

endmodule

`default_nettype wire

FILE: test/lsqr_checker.sv
// load/store queue ring: checker that watches both channels, predicts each result and compares
// depends on lsqr_pkg and lsqr_if
`timescale 1ns / 1ps

module lsqr_checker import lsqr_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  lsqr_in_if          in_mon,
  lsqr_out_if         out_mon,
  output int unsigned fail_cnt,
  output int unsigned pending_cnt,
  output int unsigned checked_cnt
);

  // shadow copy of the ring
  logic [WORD_W-1:0]    ring_pc   [QUEUE_DEPTH];
  logic [WORD_W-1:0]    ring_addr [QUEUE_DEPTH];
  logic [TAG_W-1:0]     ring_tag  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ring_live;
  logic [QUEUE_DEPTH-1:0] ring_store;
  logic [QUEUE_DEPTH-1:0] ring_aok;
  int                   head_idx;
  int                   tail_idx;
  logic                 ring_empty;

  out_beat_t            pending_results[$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got %0h expected %0h", $time, checked_cnt, field,
             got, want);
    fail_cnt++;
  endtask

  function automatic out_beat_t head_entry();
    out_beat_t r;
    r             = '0;
    r.ok          = 1'b1;
    r.slot_out    = SLOT_W'(head_idx);
    r.pc_out      = ring_pc[head_idx];
    r.store_out   = ring_store[head_idx];
    r.tag_out     = ring_tag[head_idx];
    r.addr_out    = ring_addr[head_idx];
    r.addr_ok_out = ring_aok[head_idx];
    r.live_out    = ring_live[head_idx];
    return r;
  endfunction

  // apply one queue operation to the shadow ring and work out its result
  task automatic apply_queue_op(input in_beat_t b, output out_beat_t r);
    logic [TAG_W-1:0] tag;
    int               s;
    tag = b.branch_tag & TAG_W'((1 << TAG_BITS) - 1);
    s   = int'(b.slot_in);
    r   = '0;
    case (b.func)
      FN_ALLOC: begin
        // refused when full
        if (ring_empty || (tail_idx + 1) % QUEUE_DEPTH != head_idx) begin
          if (ring_empty) begin
            head_idx   = 0;
            tail_idx   = 0;
            ring_empty = 1'b0;
          end else begin
            tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
          end
          ring_pc[tail_idx]    = b.instr_pc;
          ring_addr[tail_idx]  = '0;
          ring_tag[tail_idx]   = tag;
          ring_live[tail_idx]  = 1'b1;
          ring_store[tail_idx] = b.is_store;
          ring_aok[tail_idx]   = 1'b0;
          r.ok       = 1'b1;
          r.slot_out = SLOT_W'(tail_idx);
        end
      end
      FN_RETIRE: begin
        if (!ring_empty) begin
          r = head_entry();
          ring_live[head_idx] = 1'b0;
          if (head_idx == tail_idx) ring_empty = 1'b1;
          else head_idx = (head_idx + 1) % QUEUE_DEPTH;
        end
      end
      FN_UPDATE: begin
        if (s < QUEUE_DEPTH && ring_live[s]) begin
          ring_addr[s] = b.mem_addr_in;
          ring_aok[s]  = b.addr_ok_in;
          r.ok         = 1'b1;
        end
      end
      FN_FLUSH: begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (ring_tag[i] == tag) ring_live[i] = 1'b0;
        r.ok = 1'b1;
      end
      FN_PEEK: begin
        if (!ring_empty) r = head_entry();
      end
      default: ;
    endcase
  endtask

  task automatic compare_result(input out_beat_t got, input out_beat_t want);
    if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
    if (got.slot_out !== want.slot_out) report_mismatch("slot_out", got.slot_out, want.slot_out);
    if (got.pc_out !== want.pc_out) report_mismatch("pc_out", got.pc_out, want.pc_out);
    if (got.store_out !== want.store_out)
      report_mismatch("store_out", got.store_out, want.store_out);
    if (got.tag_out !== want.tag_out) report_mismatch("tag_out", got.tag_out, want.tag_out);
    if (got.addr_out !== want.addr_out) report_mismatch("addr_out", got.addr_out, want.addr_out);
    if (got.addr_ok_out !== want.addr_ok_out)
      report_mismatch("addr_ok_out", got.addr_ok_out, want.addr_ok_out);
    if (got.live_out !== want.live_out) report_mismatch("live_out", got.live_out, want.live_out);
  endtask

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    checked_cnt = 0;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    in_beat_t  ib;
    out_beat_t ob;
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ring_pc[i]   = '0;
        ring_addr[i] = '0;
        ring_tag[i]  = '0;
      end
      ring_live  = '0;
      ring_store = '0;
      ring_aok   = '0;
      head_idx   = 0;
      tail_idx   = 0;
      ring_empty = 1'b1;
      pending_results.delete();
    end else begin
      // accepted input beat
      if (in_mon.valid && in_mon.ready) begin
        ib.func        = in_mon.func;
        ib.instr_pc    = in_mon.instr_pc;
        ib.is_store    = in_mon.is_store;
        ib.branch_tag  = in_mon.branch_tag;
        ib.slot_in     = in_mon.slot_in;
        ib.addr_ok_in  = in_mon.addr_ok_in;
        ib.mem_addr_in = in_mon.mem_addr_in;
        apply_queue_op(ib, want);
        pending_results.push_back(want);
      end
      // accepted result beat
      if (out_mon.valid && out_mon.ready) begin
        ob.ok          = out_mon.ok;
        ob.slot_out    = out_mon.slot_out;
        ob.pc_out      = out_mon.pc_out;
        ob.store_out   = out_mon.store_out;
        ob.tag_out     = out_mon.tag_out;
        ob.addr_out    = out_mon.addr_out;
        ob.addr_ok_out = out_mon.addr_ok_out;
        ob.live_out    = out_mon.live_out;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat, ok", ob.ok, '0);
        end else begin
          want = pending_results.pop_front();
          compare_result(ob, want);
        end
        checked_cnt++;
      end
    end
    pending_cnt = pending_results.size();
  end

endmodule

FILE: test/tb_top.sv
// load/store queue ring: testbench top with clock, reset, beat stimulus and verdict
// depends on lsqr_pkg, lsqr_if, lsqr_checker and load_store_queue_ring_top
`timescale 1ns / 1ps

module tb_top;
  import lsqr_pkg::*;

  localparam int QUEUE_DEPTH = 32;
  localparam int TAG_BITS    = 4;
  localparam int RANDOM_BEATS = 2000;
  localparam int QUIET_FROM   = 1800;

  // stretch mixes of the random part
  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_BALANCED = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  bit          quiet;
  int          idle_pct;
  bit          held_off;
  int          op_seen[8];

  lsqr_in_if  in_bus ();
  lsqr_out_if out_bus ();

  load_store_queue_ring_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  lsqr_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_bus),
    .out_mon(out_bus),
    .fail_cnt(fail_cnt),
    .pending_cnt(pending_cnt),
    .checked_cnt(checked_cnt)
  );

  always #10 clk = ~clk;

  function automatic in_beat_t mk_beat(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] pc,
                                       logic st, logic [TAG_W-1:0] tag,
                                       logic [SLOT_W-1:0] slot, logic aok,
                                       logic [WORD_W-1:0] addr);
    in_beat_t b;
    b.func        = func;
    b.instr_pc    = pc;
    b.is_store    = st;
    b.branch_tag  = tag;
    b.slot_in     = slot;
    b.addr_ok_in  = aok;
    b.mem_addr_in = addr;
    return b;
  endfunction

  // random operation, weighted by the current stretch mix
  function automatic in_beat_t random_beat(int mix);
    int                alloc_w;
    int                retire_w;
    int                r;
    logic [FUNC_W-1:0] func;
    alloc_w  = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 15 : 35;
    retire_w = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 55 : 35;
    r = $urandom_range(0, 99);
    if (r < alloc_w) func = FN_ALLOC;
    else if (r < alloc_w + retire_w) func = FN_RETIRE;
    else if (r < alloc_w + retire_w + 16) func = FN_UPDATE;
    else if (r < alloc_w + retire_w + 23) func = FN_PEEK;
    else if (r < alloc_w + retire_w + 27) func = FN_FLUSH;
    else func = FUNC_W'($urandom_range(5, 7));
    return mk_beat(func, $urandom, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 15)),
                   SLOT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), $urandom);
  endfunction

  // offer one beat from a falling edge and return at the falling edge after it is taken
  task automatic send_beat(input in_beat_t b);
    if (!quiet && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.func        = b.func;
    in_bus.instr_pc    = b.instr_pc;
    in_bus.is_store    = b.is_store;
    in_bus.branch_tag  = b.branch_tag;
    in_bus.slot_in     = b.slot_in;
    in_bus.addr_ok_in  = b.addr_ok_in;
    in_bus.mem_addr_in = b.mem_addr_in;
    in_bus.valid       = 1'b1;
    op_seen[b.func]++;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // result side: random stall bursts and one long hold-off
  initial begin
    out_bus.ready = 1'b0;
    held_off      = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && checked_cnt >= 300) begin
        held_off      = 1'b1;
        out_bus.ready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int mix;
    rst_n = 1'b0;
    quiet = 1'b0;
    idle_pct = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    in_bus.valid       = 1'b0;
    in_bus.func        = '0;
    in_bus.instr_pc    = '0;
    in_bus.is_store    = 1'b0;
    in_bus.branch_tag  = '0;
    in_bus.slot_in     = '0;
    in_bus.addr_ok_in  = 1'b0;
    in_bus.mem_addr_in = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: refusals on an empty ring, a flush of it and illegal codes
    send_beat(mk_beat(FN_PEEK, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_UPDATE, '0, 1'b0, '0, 5'd0, 1'b1, 32'hFFFF_FFFF));
    send_beat(mk_beat(FN_FLUSH, '0, 1'b0, 4'd0, '0, 1'b0, '0));
    send_beat(mk_beat(3'd5, 32'hFFFF_FFFF, 1'b1, 4'hF, 5'd31, 1'b1, 32'hFFFF_FFFF));
    send_beat(mk_beat(3'd6, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(3'd7, '0, 1'b0, '0, '0, 1'b0, '0));
    // directed: fill three slots, update, peek, flush by tag, drain
    send_beat(mk_beat(FN_ALLOC, 32'h0, 1'b0, 4'h0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_ALLOC, 32'hFFFF_FFFF, 1'b1, 4'hF, '0, 1'b0, '0));
    send_beat(mk_beat(FN_ALLOC, 32'h1234_5678, 1'b0, 4'h5, '0, 1'b0, '0));
    send_beat(mk_beat(FN_UPDATE, '0, 1'b0, '0, 5'd1, 1'b1, 32'hFFFF_FFFF));
    send_beat(mk_beat(FN_UPDATE, '0, 1'b0, '0, 5'd31, 1'b1, 32'hA5A5_5A5A));
    send_beat(mk_beat(FN_PEEK, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_FLUSH, '0, 1'b0, 4'hF, '0, 1'b0, '0));
    send_beat(mk_beat(FN_UPDATE, '0, 1'b0, '0, 5'd1, 1'b0, 32'h0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));
    // directed: allocate after draining restarts at slot zero
    send_beat(mk_beat(FN_ALLOC, 32'h8000_0001, 1'b1, 4'h9, '0, 1'b0, '0));
    send_beat(mk_beat(FN_PEEK, '0, 1'b0, '0, '0, 1'b0, '0));
    send_beat(mk_beat(FN_RETIRE, '0, 1'b0, '0, '0, 1'b0, '0));

    // random stretches of fill, drain and balanced traffic
    mix = MIX_BALANCED;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        mix = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 8;
          default: idle_pct = 25;
        endcase
      end
      quiet = (n >= QUIET_FROM);
      send_beat(random_beat(mix));
    end
    in_bus.valid = 1'b0;

    // drain, then allow for a trailing flush walk
    wait (pending_cnt == 0);
    repeat (2 * QUEUE_DEPTH) @(posedge clk);

    $display("covered %0d beats: %0d alloc, %0d retire, %0d update, %0d flush, %0d peek, %0d illegal",
             op_seen.sum(), op_seen[FN_ALLOC], op_seen[FN_RETIRE], op_seen[FN_UPDATE],
             op_seen[FN_FLUSH], op_seen[FN_PEEK], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("%0d results checked over fill, drain and balanced mixes with a long output hold-off",
             checked_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lsqr_pkg.sv
rtl/lsqr_if.sv
rtl/lsqr_ctrl.sv
rtl/lsqr_dpath.sv
rtl/load_store_queue_ring_top.sv
test/lsqr_checker.sv
test/tb_top.sv
